// ===== hdl/tftw_pkg.sv =====
package tftw_pkg;

  // Payload types shared by the channel interfaces and the block.
  typedef logic [7:0]  bus_byte_t;
  typedef logic [19:0] pixel_addr_t;
  typedef logic [31:0] pixel_color_t;

  // Configuration register map, in word order.
  typedef enum logic [2:0] {
    REG_PANEL_WIDTH    = 3'd0,
    REG_PANEL_HEIGHT   = 3'd1,
    REG_BYTES_PER_PIX  = 3'd2,
    REG_ROW_WINDOW_CMD = 3'd3,
    REG_COL_WINDOW_CMD = 3'd4,
    REG_START_WR_CMD   = 3'd5,
    REG_CONT_WR_CMD    = 3'd6
  } cfg_reg_t;

  // Bus byte marking.
  localparam logic MODE_DATA    = 1'b0;
  localparam logic MODE_COMMAND = 1'b1;

  // Register reset values.
  localparam logic [10:0] PANEL_WIDTH_RST    = 11'd320;
  localparam logic [10:0] PANEL_HEIGHT_RST   = 11'd240;
  localparam logic [2:0]  BYTES_PER_PIX_RST  = 3'd2;
  localparam logic [7:0]  ROW_WINDOW_CMD_RST = 8'h2A;
  localparam logic [7:0]  COL_WINDOW_CMD_RST = 8'h2B;
  localparam logic [7:0]  START_WR_CMD_RST   = 8'h2C;
  localparam logic [7:0]  CONT_WR_CMD_RST    = 8'h3C;

  // Pixel formatting.
  localparam logic [2:0] BPP_RGB565  = 3'd2;
  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  // Window bound byte positions: first bound high/low, second bound high/low.
  localparam logic [2:0] WIN_FIRST_HI  = 3'd0;
  localparam logic [2:0] WIN_FIRST_LO  = 3'd1;
  localparam logic [2:0] WIN_SECOND_HI = 3'd2;
  localparam logic [2:0] WIN_SECOND_LO = 3'd3;

  // Expand an RGB565 word to RGB888 by left-justifying each component.
  function automatic logic [23:0] rgb565_to_888(input logic [15:0] c);
    rgb565_to_888 = {c[15:11], 3'b000, c[10:5], 2'b00, c[4:0], 3'b000};
  endfunction

endpackage

// ===== hdl/tftw_in_if.sv =====
interface tftw_in_if;
  import tftw_pkg::*;

  logic      valid;
  logic      ready;
  logic      mode;
  bus_byte_t byte_value;

  modport source (output valid, output mode, output byte_value, input ready);
  modport sink   (input valid, input mode, input byte_value, output ready);
endinterface

// ===== hdl/tftw_out_if.sv =====
interface tftw_out_if;
  import tftw_pkg::*;

  logic         valid;
  logic         ready;
  pixel_addr_t  pixel_address;
  pixel_color_t pixel_color;

  modport source (output valid, output pixel_address, output pixel_color, input ready);
  modport sink   (input valid, input pixel_address, input pixel_color, output ready);
endinterface

// ===== hdl/tft_window_pixel_writer.sv =====
// Command/data byte front end of a windowed TFT panel. Each input transfer carries one
// bus byte marked as command or data; a finished pixel inside the panel comes out as one
// transfer of framebuffer address and ARGB color. The block takes one byte per clock while
// in_if.ready is high: a byte is captured in the input register, all decoding, window, cursor
// and address work (one 11x11 multiply and add) is done once the result register can take a
// pixel, and the result register presents the pixel. in_if.ready drops only while the
// result register holds a pixel that the consumer has not taken.
module tft_window_pixel_writer #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  tftw_in_if.sink           in_if,
  tftw_out_if.source        out_if,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import tftw_pkg::*;

  localparam logic [15:0] MAX_W16 = 16'(MAX_WIDTH);
  localparam logic [15:0] MAX_H16 = 16'(MAX_HEIGHT);

  // Configuration registers.
  logic [10:0] panel_width_r, panel_height_r;
  logic [2:0]  bytes_per_pixel_r;
  logic [7:0]  row_cmd_r, col_cmd_r, start_cmd_r, cont_cmd_r;

  // Input register.
  logic      s1_valid_r;
  logic      s1_mode_r;
  bus_byte_t s1_byte_r;
  logic      s1_adv;

  // Block state.
  logic [7:0]  act_cmd_r, act_cmd_nxt;
  logic [2:0]  step_r, step_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [15:0] cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [15:0] win_top_r, win_top_nxt, win_bot_r, win_bot_nxt;
  logic [15:0] win_left_r, win_left_nxt, win_right_r, win_right_nxt;

  // Result register.
  logic         out_valid_r;
  pixel_addr_t  out_addr_r, out_addr_nxt;
  pixel_color_t out_color_r, out_color_nxt;
  logic         emit;

  // Working signals of the processing cycle.
  logic        is_row, is_col, is_start, is_cont;
  logic [2:0]  step_inc;
  logic [31:0] acc_sh;
  logic        pix_done;
  logic [15:0] base_x, base_y, step_x, step_y;
  logic [10:0] eff_w, eff_h;
  logic        in_panel;
  logic [21:0] row_base;
  logic [22:0] addr_full;
  logic [15:0] win_first, win_second, win_first_upd, win_second_upd;

  // APB write and read.
  logic     cfg_wr;
  cfg_reg_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = cfg_reg_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      panel_width_r     <= PANEL_WIDTH_RST;
      panel_height_r    <= PANEL_HEIGHT_RST;
      bytes_per_pixel_r <= BYTES_PER_PIX_RST;
      row_cmd_r         <= ROW_WINDOW_CMD_RST;
      col_cmd_r         <= COL_WINDOW_CMD_RST;
      start_cmd_r       <= START_WR_CMD_RST;
      cont_cmd_r        <= CONT_WR_CMD_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_PANEL_WIDTH:    panel_width_r     <= pwdata[10:0];
        REG_PANEL_HEIGHT:   panel_height_r    <= pwdata[10:0];
        REG_BYTES_PER_PIX:  bytes_per_pixel_r <= pwdata[2:0];
        REG_ROW_WINDOW_CMD: row_cmd_r         <= pwdata[7:0];
        REG_COL_WINDOW_CMD: col_cmd_r         <= pwdata[7:0];
        REG_START_WR_CMD:   start_cmd_r       <= pwdata[7:0];
        REG_CONT_WR_CMD:    cont_cmd_r        <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_PANEL_WIDTH:    prdata = {21'd0, panel_width_r};
      REG_PANEL_HEIGHT:   prdata = {21'd0, panel_height_r};
      REG_BYTES_PER_PIX:  prdata = {29'd0, bytes_per_pixel_r};
      REG_ROW_WINDOW_CMD: prdata = {24'd0, row_cmd_r};
      REG_COL_WINDOW_CMD: prdata = {24'd0, col_cmd_r};
      REG_START_WR_CMD:   prdata = {24'd0, start_cmd_r};
      REG_CONT_WR_CMD:    prdata = {24'd0, cont_cmd_r};
      default:            prdata = 32'd0;
    endcase
  end

  // Handshake: a held byte is processed once the result register can take a pixel.
  assign s1_adv      = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      s1_mode_r <= in_if.mode;
      s1_byte_r <= in_if.byte_value;
    end
  end

  // Command decode; the row command wins over column, start and continue.
  assign is_row   = (act_cmd_r == row_cmd_r);
  assign is_col   = !is_row && (act_cmd_r == col_cmd_r);
  assign is_start = !is_row && !is_col && (act_cmd_r == start_cmd_r);
  assign is_cont  = !is_row && !is_col && !is_start && (act_cmd_r == cont_cmd_r);

  // Pixel assembly and the cursor position used for this byte.
  assign step_inc = step_r + 3'd1;
  assign acc_sh   = {acc_r[23:0], s1_byte_r};
  assign pix_done = (step_inc == bytes_per_pixel_r);
  assign base_x   = is_start ? win_left_r : cur_x_r;
  assign base_y   = is_start ? win_top_r  : cur_y_r;

  // Cursor step with exclusive right and bottom bounds.
  always_comb begin
    step_x = base_x + 16'd1;
    step_y = base_y;
    if (step_x == win_right_r) begin
      step_x = win_left_r;
      step_y = base_y + 16'd1;
      if (step_y == win_bot_r) begin
        step_y = win_top_r;
      end
    end
  end

  // Clipping and framebuffer address.
  assign eff_w     = ({5'd0, panel_width_r}  < MAX_W16) ? panel_width_r  : MAX_W16[10:0];
  assign eff_h     = ({5'd0, panel_height_r} < MAX_H16) ? panel_height_r : MAX_H16[10:0];
  assign in_panel  = (base_x < {5'd0, eff_w}) && (base_y < {5'd0, eff_h});
  assign row_base  = {11'd0, base_y[10:0]} * {11'd0, eff_w};
  assign addr_full = {1'b0, row_base} + {12'd0, base_x[10:0]};

  // Window bound byte loads, high byte first.
  assign win_first  = is_row ? win_top_r : win_left_r;
  assign win_second = is_row ? win_bot_r : win_right_r;

  always_comb begin
    win_first_upd  = win_first;
    win_second_upd = win_second;
    case (step_r)
      WIN_FIRST_HI:  win_first_upd  = {s1_byte_r, 8'h00};
      WIN_FIRST_LO:  win_first_upd  = {win_first[15:8], s1_byte_r};
      WIN_SECOND_HI: win_second_upd = {s1_byte_r, 8'h00};
      WIN_SECOND_LO: win_second_upd = {win_second[15:8], s1_byte_r};
      default: ;
    endcase
  end

  // Next state and result of the byte in the input register.
  always_comb begin
    act_cmd_nxt   = act_cmd_r;
    step_nxt      = step_r;
    acc_nxt       = acc_r;
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    win_top_nxt   = win_top_r;
    win_bot_nxt   = win_bot_r;
    win_left_nxt  = win_left_r;
    win_right_nxt = win_right_r;
    emit          = 1'b0;
    out_addr_nxt  = addr_full[19:0];
    out_color_nxt = (bytes_per_pixel_r == BPP_RGB565) ?
                    {ALPHA_OPAQUE, rgb565_to_888(acc_sh[15:0])} :
                    {ALPHA_OPAQUE, acc_sh[23:0]};
    if (s1_mode_r == MODE_COMMAND) begin
      act_cmd_nxt = s1_byte_r;
      step_nxt    = 3'd0;
    end else if (is_row || is_col) begin
      if (!step_r[2]) begin
        step_nxt = step_inc;
        if (is_row) begin
          win_top_nxt  = win_first_upd;
          win_bot_nxt  = win_second_upd;
        end else begin
          win_left_nxt  = win_first_upd;
          win_right_nxt = win_second_upd;
        end
      end
    end else if (is_start || is_cont) begin
      if (is_start) begin
        act_cmd_nxt = cont_cmd_r;
      end
      if (pix_done) begin
        emit      = in_panel;
        acc_nxt   = 32'd0;
        step_nxt  = 3'd0;
        cur_x_nxt = step_x;
        cur_y_nxt = step_y;
      end else begin
        acc_nxt   = acc_sh;
        step_nxt  = step_inc;
        cur_x_nxt = base_x;
        cur_y_nxt = base_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_cmd_r   <= 8'd0;
      step_r      <= 3'd0;
      acc_r       <= 32'd0;
      cur_x_r     <= 16'd0;
      cur_y_r     <= 16'd0;
      win_top_r   <= 16'd0;
      win_bot_r   <= 16'd0;
      win_left_r  <= 16'd0;
      win_right_r <= 16'd0;
    end else if (s1_adv) begin
      act_cmd_r   <= act_cmd_nxt;
      step_r      <= step_nxt;
      acc_r       <= acc_nxt;
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
      win_top_r   <= win_top_nxt;
      win_bot_r   <= win_bot_nxt;
      win_left_r  <= win_left_nxt;
      win_right_r <= win_right_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= emit;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && emit) begin
      out_addr_r  <= out_addr_nxt;
      out_color_r <= out_color_nxt;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.pixel_address = out_addr_r;
  assign out_if.pixel_color   = out_color_r;

endmodule
